/* rtl/core/zfba_pkg.sv */
// zfba_pkg: shared types and constants of the zoned flash block allocator
// depends on nothing
package zfba_pkg;

    localparam int MAX_BLOCKS = 8192;
    localparam int MAX_ZONES  = 16;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    // room for a zone start plus a full 14 bit zone size without wrap
    localparam int CNT_W      = BLK_W + 2;
    localparam int ZONE_W     = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CFG_W      = 14;
    localparam int WORD_W     = 64;
    localparam int WADDR_W    = BLK_W - $clog2(WORD_W);
    localparam int NWORDS     = MAX_BLOCKS / WORD_W;

    typedef enum logic [1:0] {
        K_GET   = 2'd0,
        K_PUT   = 2'd1,
        K_ZRST  = 2'd2,
        K_ARST  = 2'd3
    } t_kind;

    localparam logic [0:0] CFG_BLOCK_COUNT = 1'b0;
    localparam logic [0:0] CFG_ZONE_BLOCKS = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ZONE_W-1:0] zone;
        logic [BLK_W-1:0]  block;
        logic              dirty_flag;
        logic [31:0]       random_word;
    } t_req;

    typedef struct packed {
        logic              found;
        logic [BLK_W-1:0]  granted_block;
        logic              granted_dirty;
    } t_rsp;

    // datapath commands, one per cycle at most
    typedef enum logic [2:0] {
        C_NONE,
        C_RD,     // read bitmap entry at position
        C_WRGET,  // mark position used in both maps and dirty
        C_WRPUT,  // put write
        C_FILL    // mark position used and dirty
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [BLK_W-1:0] pos;
        logic             put_use_b;
        logic             put_clean;
    } t_dp_cmd;

    typedef struct packed {
        logic used_a;
        logic used_b;
        logic dirty;
    } t_dp_sts;

endpackage

/* rtl/core/zfba_if.sv */
// zfba_if: valid/ready channel carrying one payload
// depends on nothing (payload type is a parameter)
interface zfba_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/zoned_flash_block_allocator_unit.sv */
// zoned_flash_block_allocator_unit: top level, wires controller and bitmap store
// depends on zfba_pkg, zfba_if, zfba_ctrl, zfba_dp
//
// one transaction at a time; after reset the block runs a clearing pass over
// all MAX_BLOCKS entries (request ready low) that marks every block used and
// dirty. a get passes through accept, the zone bounds up to its zone, the
// start computation, a start state, then a read and a check state per bitmap
// entry visited (one read port on the bitmap store) over at most three passes
// of the zone, plus grant and result states; a put steps the zone bounds to
// find the zone of the block and then writes it, a zone reset finds the bounds
// and fills each block of the zone, and a full reset fills every block. the
// result register lets the response wait while the sink stalls
module zoned_flash_block_allocator_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    zfba_if.sink                       req,
    zfba_if.source                     rsp,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [zfba_pkg::CFG_W-1:0] i_cfg_data
);
    logic [zfba_pkg::CFG_W-1:0] r_block_count, r_zone_blocks;
    zfba_pkg::t_dp_cmd cmd;
    zfba_pkg::t_dp_sts sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= zfba_pkg::CFG_W'(8192);
            r_zone_blocks <= zfba_pkg::CFG_W'(1024);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == zfba_pkg::CFG_BLOCK_COUNT) r_block_count <= i_cfg_data;
            else r_zone_blocks <= i_cfg_data;
        end
    end

    zfba_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_req_valid(req.valid), .o_req_ready(req.ready), .i_req(req.data),
        .o_rsp_valid(rsp.valid), .i_rsp_ready(rsp.ready), .o_rsp(rsp.data),
        .i_block_count(r_block_count), .i_zone_blocks(r_zone_blocks),
        .o_cmd(cmd), .i_sts(sts)
    );

    zfba_dp u_dp (.i_clk, .i_cmd(cmd), .o_sts(sts));
endmodule

/* rtl/core/zfba_dp.sv */
// zfba_dp: bitmap storage for used a, used b and dirty, one entry a cycle
// depends on zfba_pkg
module zfba_dp (
    input  logic               i_clk,
    input  zfba_pkg::t_dp_cmd  i_cmd,
    output zfba_pkg::t_dp_sts  o_sts
);
    // used bits {a, b} and dirty bit kept apart so a put needs no read
    logic [1:0] r_used  [zfba_pkg::MAX_BLOCKS];
    logic       r_dirty [zfba_pkg::MAX_BLOCKS];
    logic [1:0] r_rd_used;
    logic       r_rd_dirty;

    always_ff @(posedge i_clk) begin
        case (i_cmd.cmd)
            zfba_pkg::C_RD: begin
                r_rd_used  <= r_used[i_cmd.pos];
                r_rd_dirty <= r_dirty[i_cmd.pos];
            end
            zfba_pkg::C_WRGET, zfba_pkg::C_FILL: begin
                r_used[i_cmd.pos]  <= 2'b11;
                r_dirty[i_cmd.pos] <= 1'b1;
            end
            zfba_pkg::C_WRPUT: begin
                // used in the selected map, free in the other one
                r_used[i_cmd.pos] <= {~i_cmd.put_use_b, i_cmd.put_use_b};
                if (i_cmd.put_clean) r_dirty[i_cmd.pos] <= 1'b0;
            end
            default: ;
        endcase
    end

    assign o_sts.used_a = r_rd_used[1];
    assign o_sts.used_b = r_rd_used[0];
    assign o_sts.dirty  = r_rd_dirty;
endmodule

/* rtl/core/zfba_ctrl.sv */
// zfba_ctrl: sequencer for get, put and reset, walks the bitmap store
// depends on zfba_pkg
module zfba_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  zfba_pkg::t_req                i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output zfba_pkg::t_rsp                o_rsp,
    input  logic [zfba_pkg::CFG_W-1:0]    i_block_count,
    input  logic [zfba_pkg::CFG_W-1:0]    i_zone_blocks,
    output zfba_pkg::t_dp_cmd             o_cmd,
    input  zfba_pkg::t_dp_sts             i_sts
);
    localparam int BW = zfba_pkg::BLK_W;
    localparam int CW = zfba_pkg::CNT_W;
    localparam int ZW = zfba_pkg::ZONE_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_BND, S_MOD, S_RD, S_CHK, S_PUTZ, S_PUTW, S_FILL, S_GRANT,
        S_RESP
    } t_state;

    t_state               r_state;
    zfba_pkg::t_req       r_req;
    logic [CW-1:0]        r_lo, r_n, r_bc, r_zb;
    logic [CW-1:0]        r_i;
    logic [CW-1:0]        r_off;
    logic [CW-1:0]        r_pos;
    logic [31:0]          r_rem;
    logic [5:0]           r_mstep;
    logic [1:0]           r_pass;    // 0 first map, 1 other map, 2 match pass
    logic                 r_map_b;
    logic [CW-1:0]        r_f;
    logic                 r_dirty_f;
    logic [zfba_pkg::MAX_ZONES-1:0] r_uses_b;
    logic                 r_rsp_valid;
    zfba_pkg::t_rsp       r_rsp;
    logic [ZW-1:0]        r_pz;

    logic [CW-1:0] bc_eff, zb_eff;
    always_comb begin
        bc_eff = (CW'(i_block_count) > CW'(zfba_pkg::MAX_BLOCKS)) ?
                 CW'(zfba_pkg::MAX_BLOCKS) : CW'(i_block_count);
        zb_eff = (i_zone_blocks == '0) ? CW'(1) : CW'(i_zone_blocks);
    end

    // next position in circular order
    logic [CW-1:0] n_off;
    assign n_off = (r_off + CW'(1) == r_n) ? '0 : r_off + CW'(1);

    // restoring remainder step: subtract n << (31 - step) when it fits
    logic [4:0]  mod_sh;
    logic [31:0] mod_sub;
    logic        mod_fits;
    assign mod_sh   = 5'd31 - r_mstep[4:0];
    assign mod_sub  = 32'(r_n) << mod_sh;
    assign mod_fits = (r_rem >> mod_sh) >= 32'(r_n);

    logic hit_free;
    assign hit_free = (r_map_b ? ~i_sts.used_b : ~i_sts.used_a) &&
                      (r_pass != 2'd2 || i_sts.dirty == r_req.dirty_flag);

    always_comb begin
        o_cmd = '0;
        o_cmd.pos = r_pos[BW-1:0];
        o_cmd.put_use_b = r_uses_b[r_pz];
        o_cmd.put_clean = ~r_req.dirty_flag;
        case (r_state)
            S_RD:    o_cmd.cmd = zfba_pkg::C_RD;
            S_GRANT: o_cmd.cmd = zfba_pkg::C_WRGET;
            S_FILL:  o_cmd.cmd = zfba_pkg::C_FILL;
            S_INIT:  o_cmd.cmd = zfba_pkg::C_FILL;
            S_PUTW:  o_cmd.cmd = zfba_pkg::C_WRPUT;
            default: o_cmd.cmd = zfba_pkg::C_NONE;
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE) && !r_rsp_valid;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_pos       <= '0;
            r_uses_b    <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (r_rsp_valid && i_rsp_ready) r_rsp_valid <= 1'b0;
            case (r_state)
                // clearing pass after reset: every block used and dirty
                S_INIT: begin
                    if (r_pos + CW'(1) >= CW'(zfba_pkg::MAX_BLOCKS)) r_state <= S_IDLE;
                    r_pos <= r_pos + CW'(1);
                end
                S_IDLE: begin
                    if (i_req_valid && o_req_ready) begin
                        r_req   <= i_req;
                        r_bc    <= bc_eff;
                        r_zb    <= zb_eff;
                        r_lo    <= '0;
                        r_i     <= '0;
                        r_rsp   <= '0;
                        r_pos   <= (zfba_pkg::t_kind'(i_req.kind) == zfba_pkg::K_ARST) ?
                                   '0 : CW'(i_req.block);
                        r_rem   <= i_req.random_word;
                        r_mstep <= '0;
                        r_pz    <= '0;
                        case (zfba_pkg::t_kind'(i_req.kind))
                            zfba_pkg::K_PUT: r_state <= S_PUTZ;
                            zfba_pkg::K_ARST: begin
                                r_n   <= CW'(zfba_pkg::MAX_BLOCKS);
                                r_state <= S_FILL;
                                r_uses_b <= '0;
                            end
                            default: r_state <= S_BND;
                        endcase
                    end
                end
                // zone bounds: lo = zone*zb by repeated add over zone count
                S_BND: begin
                    if (r_i[ZW-1:0] == r_req.zone || r_i >= CW'(zfba_pkg::MAX_ZONES)) begin
                        if (r_lo >= r_bc || r_i >= CW'(zfba_pkg::MAX_ZONES)) begin
                            r_state <= S_RESP;
                        end else begin
                            if (r_req.zone == ZW'(zfba_pkg::MAX_ZONES - 1) ||
                                r_lo + r_zb > r_bc)
                                r_n <= r_bc - r_lo;
                            else
                                r_n <= r_zb;
                            r_state <= S_MOD;
                            r_mstep <= '0;
                        end
                    end else begin
                        r_lo <= (r_lo + r_zb > r_bc) ? r_bc : r_lo + r_zb;
                        r_i  <= r_i + CW'(1);
                    end
                end
                // random_word mod n, restoring, one bit a cycle; a zone reset starts its fill here instead
                S_MOD: begin
                    if (zfba_pkg::t_kind'(r_req.kind) == zfba_pkg::K_ZRST) begin
                        r_pos   <= r_lo;
                        r_n     <= r_lo + r_n;
                        r_uses_b[r_req.zone] <= 1'b0;
                        r_state <= S_FILL;
                    end else begin
                        if (mod_fits) r_rem <= r_rem - mod_sub;
                        if (r_mstep == 6'd31) begin
                            r_state <= S_RD;
                            r_pass  <= 2'd0;
                            r_map_b <= r_uses_b[r_req.zone];
                            r_i     <= '0;
                        end else begin
                            r_mstep <= r_mstep + 6'd1;
                        end
                    end
                end
                S_RD: begin
                    if (r_mstep == 6'd31) begin
                        r_off <= r_rem[CW-1:0];
                        r_pos <= r_lo + r_rem[CW-1:0];
                        r_mstep <= '0;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (hit_free) begin
                        if (r_pass == 2'd2) begin
                            r_state <= S_GRANT;
                            r_rsp.granted_dirty <= i_sts.dirty;
                        end else begin
                            r_f <= r_pos;
                            r_dirty_f <= i_sts.dirty;
                            r_pass <= 2'd2;
                            r_i <= '0;
                            r_state <= S_RD;
                        end
                    end else if (r_i + CW'(1) == r_n) begin
                        r_i <= '0;
                        if (r_pass == 2'd0) begin
                            r_off   <= n_off;
                            r_pos   <= r_lo + n_off;
                            r_pass  <= 2'd1;
                            r_map_b <= ~r_map_b;
                            r_uses_b[r_req.zone] <= ~r_uses_b[r_req.zone];
                            r_state <= S_RD;
                        end else if (r_pass == 2'd2) begin
                            r_pos <= r_f;
                            r_rsp.granted_dirty <= r_dirty_f;
                            r_state <= S_GRANT;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end else begin
                        r_i <= r_i + CW'(1);
                        r_off <= n_off;
                        r_pos <= r_lo + n_off;
                        r_state <= S_RD;
                    end
                end
                S_GRANT: begin
                    r_rsp.found <= 1'b1;
                    r_rsp.granted_block <= r_pos[BW-1:0];
                    r_state <= S_RESP;
                end
                // put: find the zone of the block by stepping zone bounds
                S_PUTZ: begin
                    if (r_pos >= r_bc) begin
                        r_state <= S_RESP;
                    end else if (r_lo + r_zb > r_pos || r_pz == ZW'(zfba_pkg::MAX_ZONES - 1)) begin
                        r_state <= S_PUTW;
                    end else begin
                        r_lo <= r_lo + r_zb;
                        r_pz <= r_pz + ZW'(1);
                    end
                end
                S_PUTW: begin
                    r_state <= S_RESP;
                end
                S_FILL: begin
                    if (r_pos + CW'(1) >= r_n) r_state <= S_RESP;
                    r_pos <= r_pos + CW'(1);
                end
                S_RESP: begin
                    r_rsp_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && !i_rsp_ready |=> r_rsp_valid) else $error("rsp dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_req_ready) else $error("accept while busy");
    a_found_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && r_rsp.found |-> r_req.kind == zfba_pkg::K_GET)
        else $error("found on non-get");
endmodule

/* sim/zfba_scoreboard.sv */
// zfba_scoreboard: watches the request, response and register channels of the
// allocator, keeps a bitmap model of it and checks every response in order
// depends on zfba_pkg
module zfba_scoreboard (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  zfba_pkg::t_req             i_req_data,
    input  logic                       i_rsp_valid,
    input  logic                       i_rsp_ready,
    input  zfba_pkg::t_rsp             i_rsp_data,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [zfba_pkg::CFG_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);

    bit [zfba_pkg::MAX_BLOCKS-1:0] used_a, used_b, dirty;
    bit [zfba_pkg::MAX_ZONES-1:0]  zone_b;
    logic [zfba_pkg::CFG_W-1:0]    blk_count, zone_size;
    zfba_pkg::t_rsp                grants_due[$];

    function automatic int live_count();
        return (blk_count > zfba_pkg::MAX_BLOCKS) ? zfba_pkg::MAX_BLOCKS : int'(blk_count);
    endfunction

    function automatic int live_zone();
        return (zone_size == 0) ? 1 : int'(zone_size);
    endfunction

    function automatic bit zone_span(int z, output int lo, output int hi);
        int l;
        l = z * live_zone();
        lo = l;
        hi = l;
        if (z >= zfba_pkg::MAX_ZONES || l >= live_count()) return 0;
        hi = (z == zfba_pkg::MAX_ZONES - 1 || l + live_zone() > live_count()) ?
             live_count() : l + live_zone();
        return 1;
    endfunction

    // first free entry in circular order from start, -1 when none
    function automatic int scan_free(bit in_b, int lo, int hi, int start,
                                     bit match, bit want);
        int n, p;
        n = hi - lo;
        for (int i = 0; i < n; i++) begin
            p = lo + (start - lo + i) % n;
            if (!(in_b ? used_b[p] : used_a[p]) && (!match || dirty[p] == want))
                return p;
        end
        return -1;
    endfunction

    function automatic zfba_pkg::t_rsp allocate(zfba_pkg::t_req r);
        zfba_pkg::t_rsp res;
        int lo, hi, start, f, c, z;
        bit in_b;
        res = '0;
        case (zfba_pkg::t_kind'(r.kind))
            zfba_pkg::K_GET: begin
                if (zone_span(r.zone, lo, hi)) begin
                    start = lo + int'(r.random_word % (hi - lo));
                    in_b = zone_b[r.zone];
                    f = scan_free(in_b, lo, hi, start, 0, 0);
                    if (f < 0) begin
                        // selected map empty: flip and try the other one
                        in_b = !in_b;
                        zone_b[r.zone] = !zone_b[r.zone];
                        f = scan_free(in_b, lo, hi, start, 0, 0);
                    end
                    if (f >= 0) begin
                        c = scan_free(in_b, lo, hi, f, 1, r.dirty_flag);
                        if (c < 0) c = f;
                        res.found = 1;
                        res.granted_block = c[zfba_pkg::BLK_W-1:0];
                        res.granted_dirty = dirty[c];
                        used_a[c] = 1;
                        used_b[c] = 1;
                        dirty[c] = 1;
                    end
                end
            end
            zfba_pkg::K_PUT: begin
                if (r.block < live_count()) begin
                    z = r.block / live_zone();
                    if (z >= zfba_pkg::MAX_ZONES) z = zfba_pkg::MAX_ZONES - 1;
                    used_a[r.block] = !zone_b[z];
                    used_b[r.block] = zone_b[z];
                    if (!r.dirty_flag) dirty[r.block] = 0;
                end
            end
            zfba_pkg::K_ZRST: begin
                if (zone_span(r.zone, lo, hi)) begin
                    for (int p = lo; p < hi; p++) begin
                        used_a[p] = 1;
                        used_b[p] = 1;
                        dirty[p] = 1;
                    end
                    zone_b[r.zone] = 0;
                end
            end
            default: begin
                used_a = '1;
                used_b = '1;
                dirty = '1;
                zone_b = '0;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        zfba_pkg::t_rsp want;
        if (!i_rst_n) begin
            used_a = '1;
            used_b = '1;
            dirty = '1;
            zone_b = '0;
            blk_count = 14'd8192;
            zone_size = 14'd1024;
            grants_due.delete();
            o_errors = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (grants_due.size() == 0) begin
                    $error("response with no request outstanding");
                    o_errors++;
                end else begin
                    want = grants_due.pop_front();
                    if (i_rsp_data.found !== want.found) begin
                        $error("found expected %0d got %0d", want.found, i_rsp_data.found);
                        o_errors++;
                    end
                    if (i_rsp_data.granted_block !== want.granted_block) begin
                        $error("granted_block expected %0d got %0d",
                               want.granted_block, i_rsp_data.granted_block);
                        o_errors++;
                    end
                    if (i_rsp_data.granted_dirty !== want.granted_dirty) begin
                        $error("granted_dirty expected %0d got %0d",
                               want.granted_dirty, i_rsp_data.granted_dirty);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == zfba_pkg::CFG_BLOCK_COUNT) blk_count = i_cfg_data;
                else zone_size = i_cfg_data;
            end
            if (i_req_valid && i_req_ready) grants_due.push_back(allocate(i_req_data));
        end
        o_pending = grants_due.size();
    end

endmodule

/* sim/tb.sv */
// tb: stimulus and verdict for zoned_flash_block_allocator_unit
// depends on zfba_pkg, zfba_if, the allocator rtl and zfba_scoreboard
module tb;

    localparam int CYCLE_LIMIT = 6000000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       cfg_we;
    logic [0:0]                 cfg_idx;
    logic [zfba_pkg::CFG_W-1:0] cfg_data;
    int                         errors, pending, cycles;
    int                         idle_pct, stall_pct;
    int                         cur_count, cur_zone;

    zfba_if #(.T(zfba_pkg::t_req)) req_ch ();
    zfba_if #(.T(zfba_pkg::t_rsp)) rsp_ch ();

    zoned_flash_block_allocator_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req        (req_ch.sink),
        .rsp        (rsp_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    zfba_scoreboard sb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_ch.valid),
        .i_req_ready (req_ch.ready),
        .i_req_data  (req_ch.data),
        .i_rsp_valid (rsp_ch.valid),
        .i_rsp_ready (rsp_ch.ready),
        .i_rsp_data  (rsp_ch.data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = !i_clk;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // response side stalls at random, rate set per phase
    always @(negedge i_clk) begin
        rsp_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    // one request transaction; valid stays high into the next call
    task automatic send_req(zfba_pkg::t_req r);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid = 0;
            req_ch.data = $bits(zfba_pkg::t_req)'({$urandom, $urandom});
            @(negedge i_clk);
        end
        req_ch.valid = 1;
        req_ch.data = r;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic req_of(zfba_pkg::t_kind k, int z, int b, int d, bit [31:0] w);
        zfba_pkg::t_req r;
        r.kind = k;
        r.zone = z[zfba_pkg::ZONE_W-1:0];
        r.block = b[zfba_pkg::BLK_W-1:0];
        r.dirty_flag = d[0];
        r.random_word = w;
        send_req(r);
    endtask

    // wait for the block to drain, then write both registers
    task automatic set_layout(int count, int zsize);
        @(negedge i_clk);
        req_ch.valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        cfg_we = 1;
        cfg_idx = zfba_pkg::CFG_BLOCK_COUNT;
        cfg_data = count[zfba_pkg::CFG_W-1:0];
        @(negedge i_clk);
        cfg_idx = zfba_pkg::CFG_ZONE_BLOCKS;
        cfg_data = zsize[zfba_pkg::CFG_W-1:0];
        @(negedge i_clk);
        cfg_we = 0;
        cur_count = (count > zfba_pkg::MAX_BLOCKS) ? zfba_pkg::MAX_BLOCKS : count;
        cur_zone = (zsize == 0) ? 1 : zsize;
    endtask

    // random mix; zones and blocks lean toward the live part of the device
    task automatic random_reqs(int n, int zmax);
        int sel, z, b;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            z = ($urandom_range(9) == 0) ? $urandom_range(zfba_pkg::MAX_ZONES - 1)
                                         : $urandom_range(zmax);
            b = ($urandom_range(19) == 0) ? $urandom_range(zfba_pkg::MAX_BLOCKS - 1)
                                          : $urandom_range(cur_count - 1);
            if (sel < 45) req_of(zfba_pkg::K_GET, z, $urandom, $urandom, $urandom);
            else if (sel < 88) req_of(zfba_pkg::K_PUT, $urandom, b, $urandom, $urandom);
            else if (sel < 99) req_of(zfba_pkg::K_ZRST, z, $urandom, $urandom, $urandom);
            else req_of(zfba_pkg::K_ARST, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        cur_count = zfba_pkg::MAX_BLOCKS;
        cur_zone = 1024;
        req_ch.valid = 0;
        req_ch.data = '0;
        rsp_ch.ready = 1;
        cfg_we = 0;
        cfg_idx = zfba_pkg::CFG_BLOCK_COUNT;
        cfg_data = '0;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: default layout, corners of every field and operation
        req_of(zfba_pkg::K_GET, 0, 0, 0, 32'h0);          // everything used: not found
        req_of(zfba_pkg::K_PUT, 0, 0, 0, 0);              // clean block at the bottom
        req_of(zfba_pkg::K_PUT, 0, 8191, 1, 0);           // dirty block at the top
        req_of(zfba_pkg::K_PUT, 0, 5, 1, 0);
        req_of(zfba_pkg::K_GET, 0, 0, 1, 32'hffff_ffff);  // prefers the dirty one
        req_of(zfba_pkg::K_GET, 0, 0, 1, 32'h0);          // falls back to clean
        req_of(zfba_pkg::K_GET, 15, 0, 0, 32'hffff_ffff); // last zone
        req_of(zfba_pkg::K_GET, 15, 0, 0, 32'h0);         // zone starts past count: not found
        req_of(zfba_pkg::K_PUT, 0, 1030, 0, 0);           // frees into map b
        req_of(zfba_pkg::K_GET, 1, 0, 0, 32'h5555_5555);
        req_of(zfba_pkg::K_PUT, 0, 1031, 0, 0);
        req_of(zfba_pkg::K_ZRST, 1, 0, 0, 0);             // zone reset drops it
        req_of(zfba_pkg::K_GET, 1, 0, 0, 32'haaaa_aaaa);
        req_of(zfba_pkg::K_PUT, 0, 2000, 0, 0);
        req_of(zfba_pkg::K_ARST, 0, 0, 0, 0);
        req_of(zfba_pkg::K_GET, 1, 0, 0, 0);

        set_layout(100, 7);
        req_of(zfba_pkg::K_PUT, 0, 99, 0, 0);
        req_of(zfba_pkg::K_PUT, 0, 100, 0, 0);            // beyond count: ignored
        req_of(zfba_pkg::K_GET, 14, 0, 0, 32'hffff_ffff); // short zone at the end
        req_of(zfba_pkg::K_GET, 15, 0, 0, 0);             // zone starts past count
        req_of(zfba_pkg::K_ZRST, 15, 0, 0, 0);

        // random phases, layouts and pacing varied
        idle_pct = 0;  stall_pct = 0;
        set_layout(64, 4);
        random_reqs(300, 15);
        idle_pct = 71; stall_pct = 0;
        set_layout(100, 7);
        random_reqs(300, 14);
        idle_pct = 0;  stall_pct = 71;
        set_layout(16383, 0);                             // over max and zero size
        cur_count = 60;                                   // keep puts near the low zones
        random_reqs(250, 14);
        idle_pct = 30; stall_pct = 30;
        set_layout(1, 1);
        random_reqs(200, 0);
        idle_pct = 0;  stall_pct = 0;
        set_layout(8192, 8192);                           // one zone spans the device
        for (int i = 0; i < 6; i++)
            req_of(zfba_pkg::K_PUT, 0, $urandom_range(8191), $urandom, 0);
        for (int i = 0; i < 4; i++) req_of(zfba_pkg::K_GET, 0, 0, $urandom, $urandom);
        set_layout(300, 37);
        for (int p = 0; p < 4; p++) begin
            idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 71 : 30) : 0;
            stall_pct = (p == 2 || p == 3) ? ((p == 2) ? 71 : 30) : 0;
            random_reqs(190, 8);
        end

        @(negedge i_clk);
        req_ch.valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/zfba_pkg.sv
rtl/core/zfba_if.sv
rtl/core/zfba_dp.sv
rtl/core/zfba_ctrl.sv
rtl/core/zoned_flash_block_allocator_unit.sv
sim/zfba_scoreboard.sv
sim/tb.sv
